/* rtl/core/dotq_pkg.sv */
// shared constants and types for the deadline ordered timer queue
// depends on nothing; imported by the interfaces, the store, the compare unit, the top level and the testbench
package dotq_pkg;

  // default sizes handed to the top level parameters
  localparam int DEF_DEPTH     = 16;
  localparam int DEF_TIME_BITS = 48;
  localparam int ID_BITS       = 8;
  localparam int KIND_BITS     = 3;

  // result kinds
  localparam logic [KIND_BITS-1:0] KIND_FIRED  = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_LEFT   = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_EMPTY  = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_ACCEPT = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_REJECT = 3'd4;

  // store port controls
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } dotq_mem_ctl_t;

endpackage

/* rtl/core/dotq_if.sv */
// request and result channel interfaces of the timer queue
// depends on dotq_pkg for field widths
interface dotq_req_if
  import dotq_pkg::*;
#(
  parameter int TIME_BITS = DEF_TIME_BITS
);
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [ID_BITS-1:0]   timer_id;
  logic [TIME_BITS-1:0] time_value;

  modport source (output valid, output mode, output timer_id, output time_value,
                  input ready);
  modport sink   (input valid, input mode, input timer_id, input time_value,
                  output ready);
endinterface

interface dotq_rsp_if
  import dotq_pkg::*;
#(
  parameter int TIME_BITS = DEF_TIME_BITS
);
  logic                 valid;
  logic                 ready;
  logic [KIND_BITS-1:0] kind;
  logic [ID_BITS-1:0]   fired_id;
  logic [TIME_BITS-1:0] time_left;
  logic                 last;

  modport source (output valid, output kind, output fired_id, output time_left,
                  output last, input ready);
  modport sink   (input valid, input kind, input fired_id, input time_left,
                  input last, output ready);
endinterface

/* rtl/core/dotq_store.sv */
// ring storage of pending timers: one write port, one registered read port
// depends on dotq_pkg for the control struct and id width
module dotq_store
  import dotq_pkg::*;
#(
  parameter int DEPTH     = DEF_DEPTH,
  parameter int TIME_BITS = DEF_TIME_BITS,
  localparam int IW       = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  dotq_mem_ctl_t        ctl,
  input  logic [IW-1:0]        wr_addr,
  input  logic [TIME_BITS-1:0] wr_due,
  input  logic [ID_BITS-1:0]   wr_id,
  input  logic [IW-1:0]        rd_addr,
  output logic [TIME_BITS-1:0] rd_due,
  output logic [ID_BITS-1:0]   rd_id
);

  logic [TIME_BITS-1:0] due_mem [DEPTH];
  logic [ID_BITS-1:0]   id_mem  [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      due_mem[wr_addr] <= wr_due;
      id_mem[wr_addr]  <= wr_id;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_due <= due_mem[rd_addr];
      rd_id  <= id_mem[rd_addr];
    end
  end

endmodule

/* rtl/core/dotq_sub.sv */
// shared subtract and compare unit: due minus now, and whether due is later
// depends on dotq_pkg only for the default width
module dotq_sub
  import dotq_pkg::*;
#(
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic [TIME_BITS-1:0] due,
  input  logic [TIME_BITS-1:0] now,
  output logic [TIME_BITS-1:0] diff,
  output logic                 later
);

  logic [TIME_BITS:0] wide;

  // borrow in the top bit means due is before now
  assign wide  = {1'b0, due} - {1'b0, now};
  assign diff  = wide[TIME_BITS-1:0];
  assign later = !wide[TIME_BITS] && (wide[TIME_BITS-1:0] != '0);

endmodule

/* rtl/core/deadline_ordered_timer_queue_core.sv */
// top level of the deadline ordered timer queue: sequencer, output register
// depends on dotq_pkg, dotq_if, dotq_store and dotq_sub
//
// Usage: requests arrive on req (valid/ready). mode 0 inserts timer_id with
// due time time_value; mode 1 runs the queue at current time time_value.
// Results leave on rsp (valid/ready), each with kind, fired_id, time_left
// and last; last marks the final result of a request.
// An insert answers once (accepted or rejected when full). A run answers
// once per expired timer in due order, then closes with the time left to
// the next timer or an empty mark.
// Sequence: req.ready is high only while the sequencer is idle. An insert
// reads stored timers from the ring store, tail first (S_INS_RD), and
// moves each one due later than the new one up one slot behind the
// shared comparator (S_INS_CMP); it then writes the new timer and
// answers in S_INS_PUT. A run reads and compares the head once per
// fired timer and once for the closing result (S_RUN_RD, S_RUN_CMP),
// or closes from S_EMPTY when the queue drains. A rejected insert goes
// straight to S_REJ, a run on an empty queue straight to S_EMPTY.
// Reset clears the pending count and ring head; stored entries are left
// as they are. When rsp stalls, the sequencer holds in its emitting state
// and no further request is taken until every result has been delivered
// into the output register.
module deadline_ordered_timer_queue_core
  import dotq_pkg::*;
#(
  parameter int DEPTH     = DEF_DEPTH,
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input logic      clk,
  input logic      rst,
  dotq_req_if.sink   req,
  dotq_rsp_if.source rsp
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS_RD  = 3'd1;
  localparam logic [2:0] S_INS_CMP = 3'd2;
  localparam logic [2:0] S_INS_PUT = 3'd3;
  localparam logic [2:0] S_REJ     = 3'd4;
  localparam logic [2:0] S_RUN_RD  = 3'd5;
  localparam logic [2:0] S_RUN_CMP = 3'd6;
  localparam logic [2:0] S_EMPTY   = 3'd7;

  logic [2:0]           state;
  logic [CW-1:0]        count;
  logic [IW-1:0]        head;
  logic [IW-1:0]        scan;
  logic [IW-1:0]        wpos;
  logic [CW-1:0]        remain;
  logic [ID_BITS-1:0]   id_r;
  logic [TIME_BITS-1:0] tv_r;

  logic                 ov;
  logic [KIND_BITS-1:0] okind;
  logic [ID_BITS-1:0]   oid;
  logic [TIME_BITS-1:0] oleft;
  logic                 olast;

  dotq_mem_ctl_t        mctl;
  logic [IW-1:0]        rd_addr;
  logic [TIME_BITS-1:0] wr_due;
  logic [ID_BITS-1:0]   wr_id;
  logic [TIME_BITS-1:0] rd_due;
  logic [ID_BITS-1:0]   rd_id;
  logic [TIME_BITS-1:0] diff;
  logic                 later;

  logic                 can_emit;
  logic                 emit;
  logic [KIND_BITS-1:0] e_kind;
  logic [ID_BITS-1:0]   e_id;
  logic [TIME_BITS-1:0] e_left;
  logic                 e_last;

  logic [IW:0]          tail_sum;
  logic [IW-1:0]        tail;
  logic [IW-1:0]        tail_dec;
  logic [IW-1:0]        scan_dec;
  logic [IW-1:0]        head_inc;
  logic                 accept;

  // ring position arithmetic
  assign tail_sum = {1'b0, head} + (IW + 1)'(count);
  assign tail     = (tail_sum >= (IW + 1)'(DEPTH)) ?
                    IW'(tail_sum - (IW + 1)'(DEPTH)) : IW'(tail_sum);
  assign tail_dec = (tail == '0) ? IW'(DEPTH - 1) : tail - IW'(1);
  assign scan_dec = (scan == '0) ? IW'(DEPTH - 1) : scan - IW'(1);
  assign head_inc = (head == IW'(DEPTH - 1)) ? '0 : head + IW'(1);

  // request handshake
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign can_emit  = !ov || rsp.ready;

  // shared compare of the entry just read against the latched time
  dotq_sub #(
    .TIME_BITS (TIME_BITS)
  ) u_sub (
    .due   (rd_due),
    .now   (tv_r),
    .diff  (diff),
    .later (later)
  );

  // store controls
  always_comb begin
    mctl.rd_en = (state == S_RUN_RD) || (state == S_INS_RD);
    mctl.wr_en = ((state == S_INS_CMP) && later) ||
                 ((state == S_INS_PUT) && can_emit);
    rd_addr    = (state == S_RUN_RD) ? head : scan;
    wr_due     = (state == S_INS_CMP) ? rd_due : tv_r;
    wr_id      = (state == S_INS_CMP) ? rd_id : id_r;
  end

  dotq_store #(
    .DEPTH     (DEPTH),
    .TIME_BITS (TIME_BITS)
  ) u_store (
    .clk     (clk),
    .ctl     (mctl),
    .wr_addr (wpos),
    .wr_due  (wr_due),
    .wr_id   (wr_id),
    .rd_addr (rd_addr),
    .rd_due  (rd_due),
    .rd_id   (rd_id)
  );

  // result selection per emitting state
  always_comb begin
    emit   = 1'b0;
    e_kind = KIND_EMPTY;
    e_id   = '0;
    e_left = '0;
    e_last = 1'b1;
    case (state)
      S_INS_PUT: begin
        emit   = can_emit;
        e_kind = KIND_ACCEPT;
        e_id   = id_r;
      end
      S_REJ: begin
        emit   = can_emit;
        e_kind = KIND_REJECT;
        e_id   = id_r;
      end
      S_RUN_CMP: begin
        emit = can_emit;
        if (later) begin
          e_kind = KIND_LEFT;
          e_left = diff;
        end else begin
          e_kind = KIND_FIRED;
          e_id   = rd_id;
          e_last = 1'b0;
        end
      end
      S_EMPTY: begin
        emit = can_emit;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      head  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (!req.mode) begin
              if (count == CW'(DEPTH)) begin
                state <= S_REJ;
              end else if (count == '0) begin
                state <= S_INS_PUT;
              end else begin
                state <= S_INS_RD;
              end
            end else begin
              state <= (count == '0) ? S_EMPTY : S_RUN_RD;
            end
          end
        end
        S_INS_RD: begin
          state <= S_INS_CMP;
        end
        S_INS_CMP: begin
          if (later && (remain != CW'(1))) begin
            state <= S_INS_RD;
          end else begin
            state <= S_INS_PUT;
          end
        end
        S_INS_PUT: begin
          if (emit) begin
            count <= count + CW'(1);
            state <= S_IDLE;
          end
        end
        S_REJ: begin
          if (emit) begin
            state <= S_IDLE;
          end
        end
        S_RUN_RD: begin
          state <= S_RUN_CMP;
        end
        S_RUN_CMP: begin
          if (emit) begin
            if (later) begin
              state <= S_IDLE;
            end else begin
              head  <= head_inc;
              count <= count - CW'(1);
              state <= (count == CW'(1)) ? S_EMPTY : S_RUN_RD;
            end
          end
        end
        S_EMPTY: begin
          if (emit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request payload and scan pointers
  always_ff @(posedge clk) begin
    if (accept) begin
      id_r   <= req.timer_id;
      tv_r   <= req.time_value;
      wpos   <= tail;
      scan   <= tail_dec;
      remain <= count;
    end else if ((state == S_INS_CMP) && later) begin
      wpos   <= scan;
      scan   <= scan_dec;
      remain <= remain - CW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (emit) begin
      ov <= 1'b1;
    end else if (rsp.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      okind <= e_kind;
      oid   <= e_id;
      oleft <= e_left;
      olast <= e_last;
    end
  end

  assign rsp.valid     = ov;
  assign rsp.kind      = okind;
  assign rsp.fired_id  = oid;
  assign rsp.time_left = oleft;
  assign rsp.last      = olast;

  // pending count stays within the ring
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("pending count above depth");

  // a closing result returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (emit && e_last) |=> (state == S_IDLE))
    else $error("closing result without return to idle");

  // every fired timer leaves the queue
  a_fire_pop: assert property (@(posedge clk) disable iff (rst)
    (emit && (e_kind == KIND_FIRED)) |=> (count == $past(count) - CW'(1)))
    else $error("fired timer not removed");

  // rejection only on a full queue
  a_reject_full: assert property (@(posedge clk) disable iff (rst)
    (emit && (e_kind == KIND_REJECT)) |-> (count == CW'(DEPTH)))
    else $error("insert rejected while not full");

endmodule

/* tb/tb_top.sv */
// self-checking testbench for deadline_ordered_timer_queue_core: directed and random
// inserts and runs, a shadow timer queue for prediction, field by field result checks
// depends on dotq_pkg, dotq_req_if, dotq_rsp_if and the core
module tb_top;
  import dotq_pkg::*;

  localparam int TB_DEPTH       = DEF_DEPTH;
  localparam int TB_TIME_BITS   = DEF_TIME_BITS;
  localparam int RANDOM_ITEMS   = 320;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int REPORT_LIMIT   = 10;
  localparam logic MODE_INSERT  = 1'b0;
  localparam logic MODE_RUN     = 1'b1;

  typedef logic [TB_TIME_BITS-1:0] tick_t;

  typedef struct packed {
    logic               mode;
    logic [ID_BITS-1:0] timer_id;
    tick_t              time_value;
  } timer_req_t;

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic [ID_BITS-1:0]   fired_id;
    tick_t                time_left;
    logic                 last;
  } timer_rsp_t;

  logic clk;
  logic rst;

  dotq_req_if #(.TIME_BITS(TB_TIME_BITS)) req_ch ();
  dotq_rsp_if #(.TIME_BITS(TB_TIME_BITS)) rsp_ch ();

  deadline_ordered_timer_queue_core #(
    .DEPTH     (TB_DEPTH),
    .TIME_BITS (TB_TIME_BITS)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // requests waiting for the driver, results owed by the block
  timer_req_t pending_reqs[$];
  timer_rsp_t results_due[$];

  // shadow copy of the timer queue
  tick_t              shadow_due[TB_DEPTH];
  logic [ID_BITS-1:0] shadow_id[TB_DEPTH];
  int                 shadow_count = 0;

  int n_inserts = 0;
  int n_rejects = 0;
  int n_runs    = 0;
  int n_fired   = 0;
  int n_checked = 0;
  int n_errors  = 0;

  // clock and reset
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.mode       = MODE_INSERT;
    req_ch.timer_id   = '0;
    req_ch.time_value = '0;
    rsp_ch.ready      = 1'b0;
    fork
      forever #6 clk = ~clk;
      begin
        repeat (7) @(posedge clk);
        rst <= 1'b0;
      end
    join_none
  end

  // update the shadow queue for one accepted request and queue its results
  function automatic void apply_timer_request(input timer_req_t r);
    int         pos;
    int         i;
    timer_rsp_t res;
    res = '0;
    if (r.mode == MODE_INSERT) begin
      res.fired_id = r.timer_id;
      res.last     = 1'b1;
      if (shadow_count >= TB_DEPTH) begin
        res.kind = KIND_REJECT;
        n_rejects++;
      end else begin
        // new timer goes behind every entry due no later than it
        pos = 0;
        while (pos < shadow_count && shadow_due[pos] <= r.time_value) pos++;
        for (i = shadow_count; i > pos; i--) begin
          shadow_due[i] = shadow_due[i-1];
          shadow_id[i]  = shadow_id[i-1];
        end
        shadow_due[pos] = r.time_value;
        shadow_id[pos]  = r.timer_id;
        shadow_count++;
        res.kind = KIND_ACCEPT;
        n_inserts++;
      end
      results_due.push_back(res);
    end else begin
      n_runs++;
      // pop every timer due at or before now
      while (shadow_count > 0 && shadow_due[0] <= r.time_value) begin
        res          = '0;
        res.kind     = KIND_FIRED;
        res.fired_id = shadow_id[0];
        results_due.push_back(res);
        for (i = 1; i < shadow_count; i++) begin
          shadow_due[i-1] = shadow_due[i];
          shadow_id[i-1]  = shadow_id[i];
        end
        shadow_count--;
        n_fired++;
      end
      res      = '0;
      res.last = 1'b1;
      if (shadow_count > 0) begin
        res.kind      = KIND_LEFT;
        res.time_left = shadow_due[0] - r.time_value;
      end else begin
        res.kind = KIND_EMPTY;
      end
      results_due.push_back(res);
    end
  endfunction

  function automatic tick_t rand_tick();
    logic [63:0] r64;
    r64 = {$urandom(), $urandom()};
    return r64[TB_TIME_BITS-1:0];
  endfunction

  task automatic add_req(input logic mode, input logic [ID_BITS-1:0] id, input tick_t tv);
    timer_req_t r;
    r.mode       = mode;
    r.timer_id   = id;
    r.time_value = tv;
    pending_reqs.push_back(r);
  endtask

  // driver: bursts of requests separated by random gaps
  timer_req_t cur_req;
  int         burst_left = 0;
  int         gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) apply_timer_request(cur_req);
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          req_ch.valid      <= 1'b1;
          req_ch.mode       <= cur_req.mode;
          req_ch.timer_id   <= cur_req.timer_id;
          req_ch.time_value <= cur_req.time_value;
          if (burst_left > 0) begin
            burst_left--;
          end else if ($urandom_range(0, 4) == 0) begin
            // long stretch with no gaps
            burst_left = $urandom_range(20, 60);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(0, 10);
            gap_left   = $urandom_range(1, 8);
          end
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: receiver ready follows a rotating pattern, checks each transaction
  logic [7:0] rdy_pat = 8'hFF;
  int         pat_age = 0;
  timer_rsp_t got;
  timer_rsp_t want;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.kind      = rsp_ch.kind;
        got.fired_id  = rsp_ch.fired_id;
        got.time_left = rsp_ch.time_left;
        got.last      = rsp_ch.last;
        n_checked++;
        if (results_due.size() == 0) begin
          if (n_errors < REPORT_LIMIT)
            $display("unexpected result: kind %0d id %0h left %0h last %0b",
                     got.kind, got.fired_id, got.time_left, got.last);
          n_errors++;
        end else begin
          want = results_due.pop_front();
          if (got.kind !== want.kind || got.fired_id !== want.fired_id ||
              got.time_left !== want.time_left || got.last !== want.last) begin
            if (n_errors < REPORT_LIMIT)
              $display("mismatch: kind %0d/%0d id %0h/%0h left %0h/%0h last %0b/%0b",
                       want.kind, got.kind, want.fired_id, got.fired_id,
                       want.time_left, got.time_left, want.last, got.last);
            n_errors++;
          end
        end
      end
      // pick a fresh stall pattern now and then, sometimes none at all
      if (pat_age == 0) begin
        if ($urandom_range(0, 9) < 3) rdy_pat = 8'hFF;
        else rdy_pat = 8'($urandom_range(0, 255)) | 8'h01;
        pat_age = $urandom_range(20, 80);
      end else begin
        rdy_pat = {rdy_pat[0], rdy_pat[7:1]};
        pat_age--;
      end
      rsp_ch.ready <= rdy_pat[0];
    end
  end

  // watchdog on cycles with no transaction on either channel
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("tb_top NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus and end of run
  initial begin
    tick_t now_t;
    tick_t due;
    tick_t last_due;
    int    n_directed;
    int    sel;
    int    k;
    int    cnt;

    // directed: extremes, equal due times, fill to full, reject, full drain, empty run
    add_req(MODE_INSERT, 8'h00, '0);
    add_req(MODE_INSERT, 8'hFF, '1);
    add_req(MODE_INSERT, 8'h5A, 48'd1000);
    add_req(MODE_INSERT, 8'hA5, 48'd1000);
    add_req(MODE_INSERT, 8'h3C, 48'd999);
    add_req(MODE_RUN, 8'($urandom_range(0, 255)), 48'd998);
    add_req(MODE_RUN, 8'($urandom_range(0, 255)), 48'd1000);
    for (k = 0; k < TB_DEPTH - 1; k++)
      add_req(MODE_INSERT, 8'(8'h10 + 8'(k * 17)), 48'hAAAA_5555_0000 - tick_t'(k));
    add_req(MODE_INSERT, 8'hC3, 48'h5555_AAAA_FFFF);
    add_req(MODE_RUN, 8'($urandom_range(0, 255)), '1);
    add_req(MODE_RUN, 8'($urandom_range(0, 255)), '0);
    n_directed = pending_reqs.size();

    // random: mostly insert bursts followed by runs a little later
    now_t    = rand_tick();
    last_due = now_t;
    while (pending_reqs.size() < n_directed + RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
        cnt = $urandom_range(1, 20);
        for (k = 0; k < cnt; k++) begin
          if ($urandom_range(0, 3) == 0) due = last_due;
          else due = now_t + tick_t'($urandom_range(0, 300));
          last_due = due;
          add_req(MODE_INSERT, 8'($urandom_range(0, 255)), due);
        end
        cnt = $urandom_range(1, 3);
        for (k = 0; k < cnt; k++) begin
          if ($urandom_range(0, 3) == 0) now_t = last_due;
          else now_t = now_t + tick_t'($urandom_range(0, 150));
          add_req(MODE_RUN, 8'($urandom_range(0, 255)), now_t);
        end
        if ($urandom_range(0, 4) == 0)
          add_req(MODE_RUN, 8'($urandom_range(0, 255)), '1);
      end else if (sel < 85) begin
        now_t = rand_tick();
        add_req(MODE_RUN, 8'($urandom_range(0, 255)), now_t);
      end else begin
        add_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), rand_tick());
      end
    end

    @(negedge rst);
    while (pending_reqs.size() > 0 || req_ch.valid || results_due.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d inserts taken, %0d rejected as full, %0d runs firing %0d timers",
             n_inserts, n_rejects, n_runs, n_fired);
    $display("checked %0d results, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0 && results_due.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/dotq_pkg.sv
rtl/core/dotq_if.sv
rtl/core/dotq_store.sv
rtl/core/dotq_sub.sv
rtl/core/deadline_ordered_timer_queue_core.sv
tb/tb_top.sv
